@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ design/dtcm_pkg.sv @@
// Package with sizes, tables and control types of the depth tile coverage map.
`timescale 1ns / 1ps

package dtcm_pkg;

    // Frame and tile geometry.
    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int TILE_WIDTH   = 10;
    localparam int TILE_HEIGHT  = 20;

    localparam int MAX_TILES  = 64;
    localparam int LEVEL_STEP = 25;
    localparam int LEVEL_MAX  = 8;
    localparam int COUNT_MAX  = 255;

    localparam int NUM_TILES = ((FRAME_WIDTH / TILE_WIDTH) > MAX_TILES) ? MAX_TILES
                                                                          : (FRAME_WIDTH / TILE_WIDTH);
    localparam int NUM_BANDS     = FRAME_HEIGHT / TILE_HEIGHT;
    localparam int LAST_BAND_ROW = NUM_BANDS * TILE_HEIGHT - 1;
    localparam bit EMIT_ON       = (NUM_TILES > 0) && (NUM_BANDS > 0);

    // Field and counter widths.
    localparam int DEPTH_W  = 16;
    localparam int LEVEL_W  = 4;
    localparam int SYMBOL_W = 7;
    localparam int COUNT_W  = 8;
    localparam int COL_W    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_W    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int OFF_W    = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
    localparam int BROW_W   = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
    localparam int RAM_DEPTH = (NUM_TILES > 0) ? NUM_TILES : 1;
    localparam int TILE_AW  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam logic [DEPTH_W-1:0] NEAR_LIMIT_RESET = 16'd1000;

    // ASCII ramp indexed by coverage level.
    localparam logic [SYMBOL_W-1:0] LEVEL_RAMP [0:LEVEL_MAX] = '{
        7'h20, 7'h2E, 7'h3A, 7'h6E, 7'h68, 7'h42, 7'h58, 7'h57, 7'h57
    };

    // Coverage level: count divided by the level step, saturated at the top level.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [COUNT_W-1:0] count);
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int k = 1; k <= LEVEL_MAX; k++) begin
            if (int'(count) >= k * LEVEL_STEP) begin
                lvl = LEVEL_W'(k);
            end
        end
        return lvl;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // pixel transaction this cycle
        logic emit_sel;  // tile store read port serves the emission sweep
        logic out_load;  // load the result register from the tile store
    } dtcm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_row;  // pixel on offer closes a band and starts emission
        logic emit_done; // result on show is the last tile of the band
    } dtcm_status_t;

endpackage

@@ design/dtcm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dtcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; a read at the written address returns old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/dtcm_ctrl.sv @@
// Controller that alternates between pixel counting and the per-band result sweep.
`timescale 1ns / 1ps

module dtcm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  dtcm_pkg::dtcm_status_t status,
    output dtcm_pkg::dtcm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_LOAD,
        ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    // Next state: a band-closing pixel starts the sweep, the last tile ends it.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_ready_reg && s_valid && status.emit_row) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (m_ready) begin
                    state_next = status.emit_done ? ST_RUN : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
        s_ready_next = (state_next == ST_RUN);
        m_valid_next = (state_next == ST_WAIT);
    end

    // State and registered handshake outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Commands to the datapath.
    always_comb begin
        cmd.take     = s_ready_reg && s_valid;
        cmd.emit_sel = (state_reg != ST_RUN);
        cmd.out_load = (state_reg == ST_LOAD);
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

@@ design/dtcm_datapath.sv @@
// Datapath: raster position, tile accumulator, tile store and result register.
`timescale 1ns / 1ps

module dtcm_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dtcm_pkg::DEPTH_W-1:0]          cfg_wr_data,
    input  logic [dtcm_pkg::DEPTH_W-1:0]          s_depth,
    input  dtcm_pkg::dtcm_cmd_t                   cmd,
    output dtcm_pkg::dtcm_status_t                status,
    output logic [dtcm_pkg::LEVEL_W-1:0]          m_level,
    output logic [dtcm_pkg::SYMBOL_W-1:0]         m_symbol,
    output logic                                  m_band_last,
    output logic                                  m_frame_last
);

    logic [dtcm_pkg::DEPTH_W-1:0]  near_limit_reg;
    logic [dtcm_pkg::COL_W-1:0]    col_reg;
    logic [dtcm_pkg::OFF_W-1:0]    off_reg;
    logic [dtcm_pkg::TILE_AW-1:0]  tile_reg;
    logic                          in_tile_reg;
    logic [dtcm_pkg::ROW_W-1:0]    row_reg;
    logic [dtcm_pkg::BROW_W-1:0]   brow_reg;
    logic [dtcm_pkg::COUNT_W-1:0]  acc_reg;
    logic [dtcm_pkg::TILE_AW-1:0]  emit_idx_reg;
    logic                          final_band_reg;
    logic                          byp_reg;
    logic [dtcm_pkg::COUNT_W-1:0]  byp_data_reg;
    logic [dtcm_pkg::LEVEL_W-1:0]  level_reg;
    logic [dtcm_pkg::SYMBOL_W-1:0] symbol_reg;
    logic                          band_last_reg;
    logic                          frame_last_reg;

    logic                          row_end;
    logic                          tile_end;
    logic                          tile_is_last;
    logic                          band_row_end;
    logic                          emit_is_last;
    logic [dtcm_pkg::TILE_AW-1:0]  next_tile;
    logic                          hit;
    logic [dtcm_pkg::COUNT_W-1:0]  base;
    logic [dtcm_pkg::COUNT_W-1:0]  sum;
    logic                          wr_en;
    logic [dtcm_pkg::TILE_AW-1:0]  rd_addr;
    logic [dtcm_pkg::COUNT_W-1:0]  ram_q;
    logic [dtcm_pkg::COUNT_W-1:0]  rd_eff;
    logic [dtcm_pkg::LEVEL_W-1:0]  lvl;

    // Position decodes.
    assign row_end      = (col_reg == dtcm_pkg::COL_W'(dtcm_pkg::FRAME_WIDTH - 1));
    assign tile_end     = (off_reg == dtcm_pkg::OFF_W'(dtcm_pkg::TILE_WIDTH - 1));
    assign tile_is_last = (tile_reg == dtcm_pkg::TILE_AW'(dtcm_pkg::NUM_TILES - 1));
    assign band_row_end = (brow_reg == dtcm_pkg::BROW_W'(dtcm_pkg::TILE_HEIGHT - 1));
    assign emit_is_last = (emit_idx_reg == dtcm_pkg::TILE_AW'(dtcm_pkg::NUM_TILES - 1));
    assign next_tile    = (row_end || tile_is_last) ? '0 : tile_reg + 1'b1;

    // Read data with forwarding of a write that went to the address read in the same cycle.
    assign rd_eff = byp_reg ? byp_data_reg : ram_q;

    // Covered-pixel test and saturating tile accumulation; band start rows begin at zero.
    always_comb begin
        hit = in_tile_reg && (s_depth != '0) && (s_depth < near_limit_reg);
        if (off_reg != '0) begin
            base = acc_reg;
        end else if (brow_reg == '0) begin
            base = '0;
        end else begin
            base = rd_eff;
        end
        if (base == dtcm_pkg::COUNT_W'(dtcm_pkg::COUNT_MAX)) begin
            sum = base;
        end else begin
            sum = base + dtcm_pkg::COUNT_W'(hit);
        end
    end

    assign wr_en = cmd.take && in_tile_reg && tile_end;

    // Read address: the sweep index, or the tile that the next pixel will open.
    always_comb begin
        if (cmd.emit_sel) begin
            rd_addr = emit_idx_reg;
        end else if (cmd.take) begin
            rd_addr = next_tile;
        end else begin
            rd_addr = tile_reg;
        end
    end

    dtcm_ram #(
        .WIDTH (dtcm_pkg::COUNT_W),
        .DEPTH (dtcm_pkg::RAM_DEPTH)
    ) u_tile_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tile_reg),
        .wr_data (sum),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Near limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_limit_reg <= dtcm_pkg::NEAR_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            near_limit_reg <= cfg_wr_data;
        end
    end

    // Raster position counters, advanced on each pixel transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            off_reg     <= '0;
            tile_reg    <= '0;
            in_tile_reg <= (dtcm_pkg::NUM_TILES > 0);
            row_reg     <= '0;
            brow_reg    <= '0;
        end else if (cmd.take) begin
            if (row_end) begin
                col_reg     <= '0;
                off_reg     <= '0;
                tile_reg    <= '0;
                in_tile_reg <= (dtcm_pkg::NUM_TILES > 0);
                if (row_reg == dtcm_pkg::ROW_W'(dtcm_pkg::FRAME_HEIGHT - 1)) begin
                    row_reg  <= '0;
                    brow_reg <= '0;
                end else begin
                    row_reg  <= row_reg + 1'b1;
                    brow_reg <= band_row_end ? '0 : brow_reg + 1'b1;
                end
            end else begin
                col_reg <= col_reg + 1'b1;
                if (tile_end) begin
                    off_reg <= '0;
                    if (tile_is_last) begin
                        in_tile_reg <= 1'b0;
                    end else begin
                        tile_reg <= tile_reg + 1'b1;
                    end
                end else begin
                    off_reg <= off_reg + 1'b1;
                end
            end
        end
    end

    // Accumulator, forwarding register and band flag.
    always_ff @(posedge aclk) begin
        byp_reg      <= wr_en && (tile_reg == rd_addr);
        byp_data_reg <= sum;
        if (cmd.take) begin
            acc_reg <= sum;
            if (row_end) begin
                final_band_reg <= (row_reg == dtcm_pkg::ROW_W'(dtcm_pkg::LAST_BAND_ROW));
            end
        end
    end

    // Sweep index over the tiles.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_idx_reg <= '0;
        end else if (cmd.take) begin
            emit_idx_reg <= '0;
        end else if (cmd.out_load && !emit_is_last) begin
            emit_idx_reg <= emit_idx_reg + 1'b1;
        end
    end

    // Result register.
    assign lvl = dtcm_pkg::level_of(rd_eff);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            level_reg      <= lvl;
            symbol_reg     <= dtcm_pkg::LEVEL_RAMP[lvl];
            band_last_reg  <= emit_is_last;
            frame_last_reg <= emit_is_last && final_band_reg;
        end
    end

    // Status to the controller.
    always_comb begin
        status.emit_row  = dtcm_pkg::EMIT_ON && row_end && band_row_end;
        status.emit_done = band_last_reg;
    end

    assign m_level      = level_reg;
    assign m_symbol     = symbol_reg;
    assign m_band_last  = band_last_reg;
    assign m_frame_last = frame_last_reg;

endmodule

@@ design/depth_tile_coverage_map_top.sv @@
// Top level of the depth tile coverage map: controller, datapath and tile store.
// Counting takes one pixel per cycle while s_ready is high; a tile's row count is written
// with its last pixel. After the last pixel of each band the input stalls while the tiles
// are read out of the tile store one at a time: each result is loaded into the result
// register and held until m_ready takes it, and input resumes after the band's last tile.
// Synchronous active-low reset clears position and control state and sets near_limit to 1000.
`timescale 1ns / 1ps

module depth_tile_coverage_map_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dtcm_pkg::DEPTH_W-1:0]       cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dtcm_pkg::DEPTH_W-1:0]       s_depth,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dtcm_pkg::LEVEL_W-1:0]       m_level,
    output logic [dtcm_pkg::SYMBOL_W-1:0]      m_symbol,
    output logic                               m_band_last,
    output logic                               m_frame_last
);

    dtcm_pkg::dtcm_cmd_t    cmd;
    dtcm_pkg::dtcm_status_t status;

    dtcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dtcm_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_depth      (s_depth),
        .cmd          (cmd),
        .status       (status),
        .m_level      (m_level),
        .m_symbol     (m_symbol),
        .m_band_last  (m_band_last),
        .m_frame_last (m_frame_last)
    );

endmodule

@@ design/dtcm_checker.sv @@
// Port-level checker for the depth tile coverage map, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtcm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dtcm_pkg::LEVEL_W-1:0]  m_level,
    input logic [dtcm_pkg::SYMBOL_W-1:0] m_symbol,
    input logic                          m_band_last,
    input logic                          m_frame_last
);

    // Pixels are never taken while a band's results are going out.
    `ASSERT_IMPLIES(a_no_take_while_emit, aclk, aresetn, m_valid, !(s_valid && s_ready))

    // The coverage level stays within the ramp.
    `ASSERT_IMPLIES(a_level_range, aclk, aresetn, m_valid, m_level <= 4'd8)

    // End of frame is only flagged on the last tile of a band.
    `ASSERT_IMPLIES(a_frame_in_band, aclk, aresetn, m_valid && m_frame_last, m_band_last)

    // A tile at level zero shows the blank symbol.
    `ASSERT_IMPLIES(a_blank_symbol, aclk, aresetn, m_valid && (m_level == 4'd0),
                    m_symbol == 7'h20)

    // A stalled result transaction holds its level and band-last flag.
    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready,
                 m_valid && $stable(m_level) && $stable(m_band_last))

endmodule

bind depth_tile_coverage_map_top dtcm_checker u_dtcm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_level      (m_level),
    .m_symbol     (m_symbol),
    .m_band_last  (m_band_last),
    .m_frame_last (m_frame_last)
);
